// ===== design/ilu_pkg.sv =====
`timescale 1ns / 1ps
package ilu_pkg;
    localparam int ITERATIONS = 8;
    localparam int QFRAC = 28;
    localparam int NORM_SHIFT = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CELL_STAGES = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_FOCAL_X = 3'd0,
        REG_INV_FOCAL_Y = 3'd1,
        REG_PRINCIPAL_X = 3'd2,
        REG_PRINCIPAL_Y = 3'd3,
        REG_RADIAL_K1   = 3'd4,
        REG_RADIAL_K2   = 3'd5,
        REG_TANG_P1     = 3'd6,
        REG_TANG_P2     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] norm_x;
        logic signed [31:0] norm_y;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
    } t_coef;

    // value flowing between cells
    typedef struct packed {
        logic               valid;
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic               sat;
    } t_link;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] v;
    } t_sat32;

    function automatic t_sat32 clamp32(input logic signed [65:0] v);
        t_sat32 r;
        if (v > 66'sd2147483647) begin
            r.sat = 1'b1;
            r.v = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            r.sat = 1'b1;
            r.v = 32'sh80000000;
        end else begin
            r.sat = 1'b0;
            r.v = v[31:0];
        end
        return r;
    endfunction

    function automatic t_sat32 qmul(input logic signed [31:0] a, input logic signed [31:0] b);
        logic signed [63:0] p;
        logic signed [65:0] s;
        p = a * b;
        s = (66'(p) + 66'sd134217728) >>> QFRAC;
        return clamp32(s);
    endfunction
endpackage

// ===== design/ilu_cell.sv =====
`timescale 1ns / 1ps
module ilu_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  ilu_pkg::t_coef i_coef,
    input  ilu_pkg::t_link i_link,
    output ilu_pkg::t_link o_link
);
    import ilu_pkg::*;

    // stage 1: squares and cross product
    t_link r_a;
    logic signed [31:0] r_x2, r_y2, r_xy;
    logic r_sa;
    // stage 2: r2, tangential sums
    t_link r_b;
    logic signed [31:0] r_b_xy, r_r2, r_tx, r_ty;
    logic r_sb;
    // stage 3: products with coefficients
    t_link r_c;
    logic signed [31:0] r_k1r2, r_k2r2, r_c_r2, r_pxy1, r_pxy2, r_ptx, r_pty;
    logic r_sc;
    // stage 4: rad
    t_link r_d;
    logic signed [31:0] r_rad, r_d_pxy1, r_d_pxy2, r_d_ptx, r_d_pty;
    logic r_sd;
    // stage 5: distortion offsets
    t_link r_e;
    logic signed [31:0] r_dx, r_dy;
    logic r_se;
    t_link r_f;

    t_sat32 n_x2, n_y2, n_xy, n_r2, n_tx, n_ty;
    t_sat32 n_k1r2, n_k2r2, n_p1xy, n_p2xy, n_ptx, n_pty;
    t_sat32 n_k2r2r2, n_rad, n_xr, n_yr, n_dx, n_dy, n_ux, n_uy;

    always_comb begin
        n_x2 = qmul(i_link.ux, i_link.ux);
        n_y2 = qmul(i_link.uy, i_link.uy);
        n_xy = qmul(i_link.ux, i_link.uy);
        n_r2 = clamp32(66'(r_x2) + 66'(r_y2));
        n_tx = clamp32(66'(n_r2.v) + 66'(r_x2) * 2);
        n_ty = clamp32(66'(n_r2.v) + 66'(r_y2) * 2);
        n_k1r2 = qmul(i_coef.k1, r_r2);
        n_k2r2 = qmul(i_coef.k2, r_r2);
        n_p1xy = qmul(i_coef.p1, r_b_xy);
        n_p2xy = qmul(i_coef.p2, r_b_xy);
        n_ptx = qmul(i_coef.p2, r_tx);
        n_pty = qmul(i_coef.p1, r_ty);
        n_k2r2r2 = qmul(r_k2r2, r_c_r2);
        n_rad = clamp32(66'(r_k1r2) + 66'(n_k2r2r2.v));
        n_xr = qmul(r_d.ux, r_rad);
        n_yr = qmul(r_d.uy, r_rad);
        n_dx = clamp32(66'(n_xr.v) + 66'(r_d_pxy1) * 2 + 66'(r_d_ptx));
        n_dy = clamp32(66'(n_yr.v) + 66'(r_d_pxy2) * 2 + 66'(r_d_pty));
        n_ux = clamp32(66'(r_e.mx) - 66'(r_dx));
        n_uy = clamp32(66'(r_e.my) - 66'(r_dy));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_b.valid <= 1'b0;
            r_c.valid <= 1'b0;
            r_d.valid <= 1'b0;
            r_e.valid <= 1'b0;
            r_f.valid <= 1'b0;
        end else if (i_en) begin
            r_a.valid <= i_link.valid;
            r_b.valid <= r_a.valid;
            r_c.valid <= r_b.valid;
            r_d.valid <= r_c.valid;
            r_e.valid <= r_d.valid;
            r_f.valid <= r_e.valid;
        end

        if (i_en) begin
            r_a.mx <= i_link.mx; r_a.my <= i_link.my;
            r_a.ux <= i_link.ux; r_a.uy <= i_link.uy; r_a.sat <= i_link.sat;
            r_x2 <= n_x2.v; r_y2 <= n_y2.v; r_xy <= n_xy.v;
            r_sa <= n_x2.sat | n_y2.sat | n_xy.sat;

            r_b.mx <= r_a.mx; r_b.my <= r_a.my;
            r_b.ux <= r_a.ux; r_b.uy <= r_a.uy; r_b.sat <= r_a.sat;
            r_b_xy <= r_xy;
            r_r2 <= n_r2.v; r_tx <= n_tx.v; r_ty <= n_ty.v;
            r_sb <= r_sa | n_r2.sat | n_tx.sat | n_ty.sat;

            r_c.mx <= r_b.mx; r_c.my <= r_b.my;
            r_c.ux <= r_b.ux; r_c.uy <= r_b.uy; r_c.sat <= r_b.sat;
            r_k1r2 <= n_k1r2.v; r_k2r2 <= n_k2r2.v; r_c_r2 <= r_r2;
            r_pxy1 <= n_p1xy.v; r_pxy2 <= n_p2xy.v; r_ptx <= n_ptx.v; r_pty <= n_pty.v;
            r_sc <= r_sb | n_k1r2.sat | n_k2r2.sat | n_p1xy.sat | n_p2xy.sat
                    | n_ptx.sat | n_pty.sat;

            r_d.mx <= r_c.mx; r_d.my <= r_c.my;
            r_d.ux <= r_c.ux; r_d.uy <= r_c.uy; r_d.sat <= r_c.sat;
            r_rad <= n_rad.v;
            r_d_pxy1 <= r_pxy1; r_d_pxy2 <= r_pxy2; r_d_ptx <= r_ptx; r_d_pty <= r_pty;
            r_sd <= r_sc | n_k2r2r2.sat | n_rad.sat;

            r_e.mx <= r_d.mx; r_e.my <= r_d.my;
            r_e.ux <= r_d.ux; r_e.uy <= r_d.uy; r_e.sat <= r_d.sat;
            r_dx <= n_dx.v; r_dy <= n_dy.v;
            r_se <= r_sd | n_xr.sat | n_yr.sat | n_dx.sat | n_dy.sat;

            r_f.mx <= r_e.mx; r_f.my <= r_e.my;
            r_f.ux <= n_ux.v; r_f.uy <= n_uy.v;
            r_f.sat <= r_e.sat | r_se | n_ux.sat | n_uy.sat;
        end
    end

    assign o_link = r_f;
endmodule

// ===== design/ilu_norm.sv =====
`timescale 1ns / 1ps
module ilu_norm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  ilu_pkg::t_in_item i_item,
    input  logic [31:0]       i_inv_fx,
    input  logic [31:0]       i_inv_fy,
    input  logic [15:0]       i_cx,
    input  logic [15:0]       i_cy,
    output ilu_pkg::t_link    o_link
);
    import ilu_pkg::*;

    logic r_v1;
    logic signed [49:0] r_px, r_py;
    t_link r_out;
    logic signed [16:0] n_dx, n_dy;
    t_sat32 n_nx, n_ny;

    always_comb begin
        n_dx = $signed({1'b0, i_item.pixel_x}) - $signed({1'b0, i_cx});
        n_dy = $signed({1'b0, i_item.pixel_y}) - $signed({1'b0, i_cy});
        n_nx = clamp32(66'((r_px + 50'sd8) >>> NORM_SHIFT));
        n_ny = clamp32(66'((r_py + 50'sd8) >>> NORM_SHIFT));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_out.valid <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_out.valid <= r_v1;
        end

        if (i_en) begin
            r_px <= n_dx * $signed({1'b0, i_inv_fx});
            r_py <= n_dy * $signed({1'b0, i_inv_fy});
            r_out.mx <= n_nx.v;
            r_out.my <= n_ny.v;
            r_out.ux <= n_nx.v;
            r_out.uy <= n_ny.v;
            r_out.sat <= n_nx.sat | n_ny.sat;
        end
    end

    assign o_link = r_out;
endmodule

// ===== design/iterative_lens_undistortion.sv =====
`timescale 1ns / 1ps
// ilu_norm feeds a chain of ITERATIONS cells of 6 stages each, then the output register
// throughput: one transaction per cycle while the output is not stalled
// a stall on the output while it holds a valid result freezes the whole chain and stalls the input in the same cycle
// reset (synchronous, active low) clears valid bits and loads the register reset values
module iterative_lens_undistortion (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  ilu_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output ilu_pkg::t_out_item o_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import ilu_pkg::*;

    logic [31:0] r_inv_fx, r_inv_fy;
    logic [15:0] r_cx, r_cy;
    t_coef r_coef;
    t_link w_link [0:ITERATIONS];
    t_out_item r_out;
    logic r_out_v;
    logic w_en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_fx <= '0;
            r_inv_fy <= '0;
            r_cx <= '0;
            r_cy <= '0;
            r_coef.k1 <= -32'sd76076785;
            r_coef.k2 <= 32'sd19853237;
            r_coef.p1 <= 32'sd51966;
            r_coef.p2 <= 32'sd4729;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_INV_FOCAL_X: r_inv_fx <= i_cfg_data;
                REG_INV_FOCAL_Y: r_inv_fy <= i_cfg_data;
                REG_PRINCIPAL_X: r_cx <= i_cfg_data[15:0];
                REG_PRINCIPAL_Y: r_cy <= i_cfg_data[15:0];
                REG_RADIAL_K1:   r_coef.k1 <= i_cfg_data;
                REG_RADIAL_K2:   r_coef.k2 <= i_cfg_data;
                REG_TANG_P1:     r_coef.p1 <= i_cfg_data;
                REG_TANG_P2:     r_coef.p2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // chain advances unless output holds a result that is stalled
    assign w_en = !(r_out_v && i_stall);
    assign o_stall = !w_en;

    ilu_norm u_norm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(i_valid),
        .i_item(i_data), .i_inv_fx(r_inv_fx), .i_inv_fy(r_inv_fy),
        .i_cx(r_cx), .i_cy(r_cy), .o_link(w_link[0])
    );

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
        ilu_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_coef(r_coef),
            .i_link(w_link[g]), .o_link(w_link[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_link[ITERATIONS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.norm_x <= w_link[ITERATIONS].ux;
            r_out.norm_y <= w_link[ITERATIONS].uy;
            r_out.saturated <= w_link[ITERATIONS].sat;
        end
    end

    assign o_valid = r_out_v;
    assign o_data = r_out;
endmodule

// ===== design/ilu_checker.sv =====
`timescale 1ns / 1ps
module ilu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input ilu_pkg::t_out_item o_data
);
    a_stall_only_when_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall)) else $error("input stalled without output stall");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data))) else $error("output changed");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("valid after reset");
endmodule

bind iterative_lens_undistortion ilu_checker u_ilu_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
);
